@@ hw/rtl/i2cms_pkg.sv @@
`timescale 1ns / 1ps

package i2cms_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam logic [7:0] PHASE_LEN_RESET = 8'd4;

    // Classified command: data is the byte shifted on the bus (write data or
    // the slave's byte), ack is the ack bit involved (slave ack or our ack).
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       ack;
    } t_cmd;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       samp;
        logic       last;
        logic [7:0] rbyte;
        logic       ack;
    } t_phase;

    // Bus levels of one phase: tail selects the ack slot of a byte command,
    // bitn the bit in flight (MSB first), sub the phase within a bit or slot.
    function automatic t_phase phase_gen(t_cmd c, logic tail, logic [2:0] bitn,
                                         logic [1:0] sub);
        t_phase p;
        logic   b;
        p = '0;
        b = c.data[3'd7 - bitn];
        unique case (c.op)
            OP_START: begin
                p.scl  = (sub == 2'd1) || (sub == 2'd2);
                p.sda  = (sub == 2'd0) || (sub == 2'd1);
                p.last = (sub == 2'd3);
            end
            OP_STOP: begin
                p.scl  = (sub == 2'd1) || (sub == 2'd2);
                p.sda  = (sub == 2'd2) || (sub == 2'd3);
                p.last = (sub == 2'd3);
            end
            OP_WRITE: begin
                if (tail) begin
                    p.scl  = (sub == 2'd1) || (sub == 2'd2);
                    p.sda  = 1'b1;
                    p.samp = (sub == 2'd2);
                    p.last = (sub == 2'd3);
                    p.ack  = (sub == 2'd3) ? c.ack : 1'b0;
                end else begin
                    p.scl = (sub == 2'd1);
                    p.sda = b;
                end
            end
            OP_READ: begin
                if (tail) begin
                    p.scl   = (sub == 2'd1);
                    p.sda   = c.ack;
                    p.last  = (sub == 2'd2);
                    p.rbyte = (sub == 2'd2) ? c.data : 8'd0;
                end else begin
                    p.scl  = (sub == 2'd1);
                    p.sda  = 1'b1;
                    p.samp = (sub == 2'd1);
                end
            end
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

@@ hw/rtl/i2cms_front.sv @@
`timescale 1ns / 1ps

module i2cms_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_operation,
    input  logic [7:0]          i_write_data,
    input  logic                i_ack_to_send,
    input  logic [7:0]          i_slave_byte,
    input  logic                i_slave_ack,
    output logic                o_push,
    output i2cms_pkg::t_cmd     o_cmd,
    input  logic                i_full
);

    logic            r_valid;
    i2cms_pkg::t_cmd r_cmd;
    i2cms_pkg::t_cmd n_cmd;
    logic            accept;

    assign o_push  = r_valid && !i_full;
    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_cmd   = r_cmd;

    // keep only the byte and ack bit that the command actually uses
    always_comb begin
        n_cmd    = '0;
        n_cmd.op = i_operation;
        unique case (i_operation)
            i2cms_pkg::OP_WRITE: begin
                n_cmd.data = i_write_data;
                n_cmd.ack  = i_slave_ack;
            end
            i2cms_pkg::OP_READ: begin
                n_cmd.data = i_slave_byte;
                n_cmd.ack  = i_ack_to_send;
            end
            default: begin
                n_cmd.data = 8'd0;
                n_cmd.ack  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ hw/rtl/i2cms_queue.sv @@
`timescale 1ns / 1ps

module i2cms_queue #(
    parameter int Depth = i2cms_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  i2cms_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output i2cms_pkg::t_cmd o_cmd
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

    i2cms_pkg::t_cmd r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ hw/rtl/i2cms_back.sv @@
`timescale 1ns / 1ps

module i2cms_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_phase_length,
    input  logic            i_empty,
    input  i2cms_pkg::t_cmd i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output i2cms_pkg::t_phase o_phase
);

    logic              r_busy;
    i2cms_pkg::t_cmd   r_cmd;
    logic              r_tail;
    logic [2:0]        r_bit;
    logic [1:0]        r_sub;
    logic [7:0]        r_timer;
    logic              r_ovalid;
    i2cms_pkg::t_phase r_phase;
    i2cms_pkg::t_phase n_phase;
    logic              taken;
    logic              emit;
    logic              body_end;

    assign o_pop   = !r_busy && !i_empty;
    assign taken   = r_ovalid && !i_stall;
    // a new phase goes out once the previous one has been held long enough
    // and the output register is free
    assign emit    = r_busy && (r_timer == 8'd0) && (!r_ovalid || taken);
    assign n_phase = i2cms_pkg::phase_gen(r_cmd, r_tail, r_bit, r_sub);
    assign body_end = (r_cmd.op == i2cms_pkg::OP_WRITE) ? (r_sub == 2'd2)
                                                        : (r_sub == 2'd1);
    assign o_valid = r_ovalid;
    assign o_phase = r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_tail   <= 1'b0;
            r_bit    <= 3'd0;
            r_sub    <= 2'd0;
            r_timer  <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (taken) begin
                r_ovalid <= 1'b0;
            end

            if (emit) begin
                r_timer <= (i_phase_length == 8'd0) ? 8'd0 : i_phase_length - 8'd1;
            end else if (r_timer != 8'd0) begin
                r_timer <= r_timer - 8'd1;
            end

            if (o_pop) begin
                r_busy <= 1'b1;
                r_tail <= 1'b0;
                r_bit  <= 3'd0;
                r_sub  <= 2'd0;
            end else if (emit) begin
                priority if (n_phase.last) begin
                    r_busy <= 1'b0;
                end else if (r_tail || r_cmd.op == i2cms_pkg::OP_START
                             || r_cmd.op == i2cms_pkg::OP_STOP) begin
                    r_sub <= r_sub + 2'd1;
                end else if (body_end) begin
                    r_sub <= 2'd0;
                    if (r_bit == 3'd7) begin
                        r_tail <= 1'b1;
                    end else begin
                        r_bit <= r_bit + 3'd1;
                    end
                end else begin
                    r_sub <= r_sub + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_phase <= n_phase;
        end
    end

endmodule

@@ hw/rtl/i2c_master_byte_sequencer.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// command   in         i_valid / o_stall  operation, write_data, ack_to_send,
//                                         slave_byte, slave_ack
// phase     out        o_valid / i_stall  scl_level, sda_level, sample_point,
//                                         last_phase, read_byte, ack_received
// config    in         i_cfg_wr_en        i_cfg_wr_data = phase_length
//
// Start/stop, read and write take 4, 19 and 28 bus phases. The queue pull hides
// under the last hold, except at length 0 or 1, where it delays the next phase.
// An accepted command passes the input register, the queue and the command
// register before its first phase leaves the phase register. Reset is synchronous,
// active low; phase_length returns to 4. A stalled phase holds; the next one waits
// for the stall and the hold time. Commands queue up until queue and input register fill.

module i2c_master_byte_sequencer #(
    parameter int QueueDepth = i2cms_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_write_data,
    input  logic       i_ack_to_send,
    input  logic [7:0] i_slave_byte,
    input  logic       i_slave_ack,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_sample_point,
    output logic       o_last_phase,
    output logic [7:0] o_read_byte,
    output logic       o_ack_received
);

    logic              r_phase_length;
    logic [7:0]        r_phase_len;
    logic              push;
    logic              full;
    logic              pop;
    logic              empty;
    i2cms_pkg::t_cmd   front_cmd;
    i2cms_pkg::t_cmd   queue_cmd;
    i2cms_pkg::t_phase phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_len <= i2cms_pkg::PHASE_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_phase_len <= i_cfg_wr_data;
        end
    end

    // marks that the length register has been written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_length <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_phase_length <= 1'b1;
        end
    end

    i2cms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_write_data (i_write_data),
        .i_ack_to_send(i_ack_to_send),
        .i_slave_byte (i_slave_byte),
        .i_slave_ack  (i_slave_ack),
        .o_push       (push),
        .o_cmd        (front_cmd),
        .i_full       (full)
    );

    i2cms_queue #(
        .Depth(QueueDepth)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (front_cmd),
        .o_full (full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_cmd  (queue_cmd)
    );

    i2cms_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_length((r_phase_length || r_phase_len != 8'd0) ? r_phase_len : 8'd1),
        .i_empty       (empty),
        .i_cmd         (queue_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_phase       (phase)
    );

    assign o_scl_level    = phase.scl;
    assign o_sda_level    = phase.sda;
    assign o_sample_point = phase.samp;
    assign o_last_phase   = phase.last;
    assign o_read_byte    = phase.rbyte;
    assign o_ack_received = phase.ack;

endmodule
